>>> rtl/core/thbs_pkg.sv
// types, constants and status codes shared by the toggle handshake bit sender
`timescale 1ns / 1ps
`default_nettype none

package thbs_pkg;

   localparam int MAX_WORD_BITS   = 64;
   localparam int WAIT_COUNT_BITS = 16;

   localparam int WORD_BITS       = 64;
   localparam int SHIFT_SEL_BITS  = $clog2(WORD_BITS);
   localparam int WORD_WIDTH_BITS = 7;
   localparam int WAIT_LIMIT_BITS = 16;
   localparam int BIT_INDEX_BITS  = 7;
   localparam int STATUS_BITS     = 3;
   localparam int CMP_BITS        = (WAIT_COUNT_BITS > WAIT_LIMIT_BITS) ?
                                    WAIT_COUNT_BITS : WAIT_LIMIT_BITS;

   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WORD_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAIT_LIMIT = 1'b1;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   localparam logic [STATUS_BITS-1:0] ST_IDLE     = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_SENT     = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_WAIT     = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_DONE     = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_TIMEOUT  = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_TERM_ERR = 3'd5;
   localparam logic [STATUS_BITS-1:0] ST_REJECT   = 3'd6;

   localparam logic [WORD_WIDTH_BITS-1:0] RESET_WORD_WIDTH = 7'd8;
   localparam logic [WAIT_LIMIT_BITS-1:0] RESET_WAIT_LIMIT = '0;

   typedef struct packed {
      logic                   kind;
      logic [WORD_BITS-1:0]   word;
      logic                   rx_sample;
   } req_payload_type;

   typedef struct packed {
      logic                      data_pin;
      logic                      tx_pin;
      logic [STATUS_BITS-1:0]    status;
      logic [BIT_INDEX_BITS-1:0] bits_sent;
   } rsp_payload_type;

   typedef struct packed {
      logic [WORD_WIDTH_BITS-1:0] word_width;
      logic [WAIT_LIMIT_BITS-1:0] wait_limit;
   } cfg_type;

   typedef struct packed {
      logic                       busy;
      logic [WORD_BITS-1:0]       shift_word;
      logic [BIT_INDEX_BITS-1:0]  bit_index;
      logic                       data_level;
      logic                       tx_level;
      logic                       rx_last;
      logic [WAIT_COUNT_BITS-1:0] wait_count;
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/thbs_if.sv
// request and response channel interfaces of the toggle handshake bit sender
`timescale 1ns / 1ps
`default_nettype none

interface thbs_req_if
   import thbs_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [WORD_BITS-1:0] word;
   logic                 rx_sample;

   modport source (output valid, output kind, output word, output rx_sample, input ready);
   modport sink   (input valid, input kind, input word, input rx_sample, output ready);
endinterface

interface thbs_rsp_if
   import thbs_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic                      data_pin;
   logic                      tx_pin;
   logic [STATUS_BITS-1:0]    status;
   logic [BIT_INDEX_BITS-1:0] bits_sent;

   modport source (output valid, output data_pin, output tx_pin, output status,
                   output bits_sent, input ready);
   modport sink   (input valid, input data_pin, input tx_pin, input status,
                   input bits_sent, output ready);
endinterface

`default_nettype wire

>>> rtl/core/thbs_step.sv
// next-state and result logic for one request transfer
`timescale 1ns / 1ps
`default_nettype none

module thbs_step
   import thbs_pkg::*;
(
   input  wire state_type       state,
   input  wire cfg_type         cfg,
   input  wire req_payload_type req,
   output state_type            state_next,
   output rsp_payload_type      rsp
);

   localparam logic [WAIT_COUNT_BITS-1:0] COUNT_MASK = '1;

   function automatic state_type drive_bit(input state_type s);
      state_type r;
      r            = s;
      r.data_level = s.shift_word[s.bit_index[SHIFT_SEL_BITS-1:0]];
      r.bit_index  = s.bit_index + 1'b1;
      r.tx_level   = ~s.tx_level;
      r.wait_count = '0;
      return r;
   endfunction

   logic [WORD_WIDTH_BITS-1:0] eff_width;
   logic [CMP_BITS-1:0]        mask_ext;
   logic [CMP_BITS-1:0]        lim_ext;
   logic [CMP_BITS-1:0]        count_next;
   logic [STATUS_BITS-1:0]     status;
   state_type                  nxt;
   state_type                  loaded;

   always_comb begin
      if (cfg.word_width == '0) begin
         eff_width = WORD_WIDTH_BITS'(1);
      end else if (cfg.word_width > WORD_WIDTH_BITS'(MAX_WORD_BITS)) begin
         eff_width = WORD_WIDTH_BITS'(MAX_WORD_BITS);
      end else begin
         eff_width = cfg.word_width;
      end

      mask_ext = CMP_BITS'(COUNT_MASK);
      lim_ext  = CMP_BITS'(cfg.wait_limit);
      if (lim_ext > mask_ext) begin
         lim_ext = mask_ext;
      end
      if (state.wait_count == COUNT_MASK) begin
         count_next = mask_ext;
      end else begin
         count_next = CMP_BITS'(state.wait_count) + 1'b1;
      end

      loaded            = state;
      loaded.shift_word = req.word;
      loaded.bit_index  = '0;
      loaded.busy       = 1'b1;

      nxt    = state;
      status = ST_IDLE;
      if (req.kind == KIND_START) begin
         if (state.busy) begin
            status = ST_REJECT;
         end else begin
            nxt    = drive_bit(loaded);
            status = ST_SENT;
         end
      end else if (!state.busy) begin
         status = ST_IDLE;
      end else if (req.rx_sample != state.rx_last) begin
         nxt.rx_last    = req.rx_sample;
         nxt.wait_count = '0;
         if (state.bit_index >= eff_width) begin
            nxt.busy = 1'b0;
            status   = state.tx_level ? ST_TERM_ERR : ST_DONE;
         end else begin
            nxt         = drive_bit(state);
            nxt.rx_last = req.rx_sample;
            status      = ST_SENT;
         end
      end else if (cfg.wait_limit == '0) begin
         status = ST_WAIT;
      end else if (count_next >= lim_ext) begin
         nxt.wait_count = '0;
         status         = ST_TIMEOUT;
      end else begin
         nxt.wait_count = count_next[WAIT_COUNT_BITS-1:0];
         status         = ST_WAIT;
      end
   end

   assign state_next    = nxt;
   assign rsp.data_pin  = nxt.data_level;
   assign rsp.tx_pin    = nxt.tx_level;
   assign rsp.status    = status;
   assign rsp.bits_sent = nxt.bit_index;

endmodule

`default_nettype wire

>>> rtl/core/toggle_handshake_bit_sender.sv
// top level of the toggle handshake bit sender: state, config and response registers
// The sender takes one request transfer per clock unless a pending response is held:
// a start while idle loads a word and drives bit 0 (while busy it is rejected), a tick
// samples rx and advances on a toggle, and every request yields exactly one response,
// registered and valid in the next cycle. The throughput is one item per cycle, set by
// the single combinational step between the state register and the response register;
// a pending response blocks new requests until it is taken. Configuration writes (word
// width, wait limit) take effect on the next request.
`timescale 1ns / 1ps
`default_nettype none

module toggle_handshake_bit_sender
   import thbs_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data,
   thbs_req_if.sink                       req_if,
   thbs_rsp_if.source                     rsp_if
);

   state_type       state_ff;
   state_type       state_in;
   cfg_type         cfg_ff;
   cfg_type         cfg_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;
   rsp_payload_type step_rsp;
   state_type       step_state;
   req_payload_type req_data;
   logic            req_ready;
   logic            req_accept;

   assign req_data.kind      = req_if.kind;
   assign req_data.word      = req_if.word;
   assign req_data.rx_sample = req_if.rx_sample;

   assign req_ready    = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_ready;
   assign req_if.ready = req_ready;

   thbs_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .req        (req_data),
      .state_next (step_state),
      .rsp        (step_rsp)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_WORD_WIDTH: cfg_in.word_width = csr_data[WORD_WIDTH_BITS-1:0];
            CSR_WAIT_LIMIT: cfg_in.wait_limit = csr_data[WAIT_LIMIT_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end

      state_in     = state_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         state_in     = step_state;
         rsp_data_in  = step_rsp;
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= '0;
         cfg_ff.word_width <= RESET_WORD_WIDTH;
         cfg_ff.wait_limit <= RESET_WAIT_LIMIT;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.data_pin  = rsp_data_ff.data_pin;
   assign rsp_if.tx_pin    = rsp_data_ff.tx_pin;
   assign rsp_if.status    = rsp_data_ff.status;
   assign rsp_if.bits_sent = rsp_data_ff.bits_sent;

   // a transfer always leaves a response pending
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   // a start while idle sends exactly the first bit
   assert property (@(posedge clock) disable iff (reset)
      req_accept && !state_ff.busy && req_if.kind == KIND_START |=>
         rsp_data_ff.status == ST_SENT && rsp_data_ff.bits_sent == BIT_INDEX_BITS'(1))
      else $error("start from idle did not send bit 0");

   // idle sender keeps its wait counter cleared
   assert property (@(posedge clock) disable iff (reset)
      !state_ff.busy |-> state_ff.wait_count == '0)
      else $error("wait counter running while idle");

   // bit index never runs past the widest word
   assert property (@(posedge clock) disable iff (reset)
      state_ff.bit_index <= BIT_INDEX_BITS'(MAX_WORD_BITS))
      else $error("bit index beyond word width");

endmodule

`default_nettype wire
